/* hdl/prv_pkg.sv */
// Shared constants for the primitive to Roe vector converter.
package prv_pkg;

    localparam int WORD = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAS_CONSTANT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMPERATURE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_VELOCITY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_LENGTH = 3'd4;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_TEMP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

endpackage

/* hdl/primitive_to_roe_vector.sv */
// Top level: primitive variables of one mesh point to its Roe parameter vector.
//
// Input channel i_valid/o_ready carries one mesh point per item (pressure,
// temperature, velocity, coordinates, last mark); output channel
// o_valid/i_ready carries the Roe vector, scaled coordinates and status.
// Configuration registers are written over i_cfg_valid/i_cfg_index/
// i_cfg_data, always ready; write them only while no item is in flight.
// Throughput is one item per cycle while the receiver does not stall. Path:
// three 33-stage dividers in series for density, two product stages and a
// clamp and sum stage, one stage per bit of the square root, then product
// and output stages.
// Reset empties the pipeline and restores the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// while the final stage is empty the pipeline advances, so new items are taken.
// Status: zero temperature forces the four Roe outputs to zero and takes
// priority; otherwise any clamp in any step reports saturation.
module primitive_to_roe_vector #(
    parameter int FRAC_BITS = prv_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [31:0]                      i_pressure,
    input  logic [31:0]                      i_temperature,
    input  logic signed [31:0]               i_velocity_x,
    input  logic signed [31:0]               i_velocity_y,
    input  logic signed [31:0]               i_coord_x,
    input  logic signed [31:0]               i_coord_y,
    input  logic                             i_last_point,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [31:0]                      o_root_density,
    output logic signed [31:0]               o_root_density_enthalpy,
    output logic signed [31:0]               o_root_density_velocity_x,
    output logic signed [31:0]               o_root_density_velocity_y,
    output logic signed [31:0]               o_scaled_x,
    output logic signed [31:0]               o_scaled_y,
    output logic                             o_last_out,
    output logic [prv_pkg::STATUS_W-1:0]     o_status,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [prv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);

    localparam int W = prv_pkg::WORD;
    localparam int RAD_W = W + FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int KIN_W = 2 * W - 1 - FRAC_BITS;
    localparam logic [W-1:0] ONE = W'(64'd1 << FRAC_BITS);
    localparam logic [W-1:0] GAMMA_RST = W'((64'd7 << FRAC_BITS) / 5);

    typedef struct packed {
        logic [W-1:0] temp;
        logic [W-1:0] help;
        logic [W-1:0] hent;
        logic         ux_neg;
        logic [W-1:0] ux_mag;
        logic         uy_neg;
        logic [W-1:0] uy_mag;
        logic         x_neg;
        logic [W-1:0] x_quo;
        logic         y_neg;
        logic [W-1:0] y_quo;
        logic         last;
        logic         tzero;
        logic         sat;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    function automatic logic [W:0] f_clamp(input logic [63:0] v);
        f_clamp = (v > 64'hFFFF_FFFF) ? {1'b1, {W{1'b1}}} : {1'b0, v[W-1:0]};
    endfunction

    // apply sign to a magnitude, saturating to the signed word range
    function automatic logic [W:0] f_sign(input logic neg, input logic [63:0] mag);
        logic [63:0] m;
        logic        s;
        m = mag;
        s = 1'b0;
        if (!neg) begin
            if (m > 64'h7FFF_FFFF) begin
                s = 1'b1;
                m = 64'h7FFF_FFFF;
            end
            f_sign = {s, m[W-1:0]};
        end else begin
            if (m > 64'h8000_0000) begin
                s = 1'b1;
                m = 64'h8000_0000;
            end
            f_sign = {s, W'(0) - m[W-1:0]};
        end
    endfunction

    // ---------------- configuration ----------------
    logic [W-1:0] r_gas, r_tref, r_uref, r_gamma, r_gm1, r_lref;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas   <= ONE;
            r_tref  <= ONE;
            r_uref  <= ONE;
            r_gamma <= GAMMA_RST;
            r_gm1   <= GAMMA_RST - ONE;
            r_lref  <= ONE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                prv_pkg::CFG_GAS_CONSTANT:    r_gas  <= i_cfg_data;
                prv_pkg::CFG_REF_TEMPERATURE: r_tref <= i_cfg_data;
                prv_pkg::CFG_REF_VELOCITY:    r_uref <= i_cfg_data;
                prv_pkg::CFG_HEAT_RATIO: begin
                    r_gamma <= i_cfg_data;
                    r_gm1   <= (i_cfg_data > ONE) ? (i_cfg_data - ONE) : '0;
                end
                prv_pkg::CFG_REF_LENGTH:      r_lref <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic adv;
    logic r7_vld;

    assign adv     = i_ready | ~r7_vld;
    assign o_ready = adv;

    // ---------------- entry ----------------
    t_item in_item;

    always_comb begin
        in_item        = '0;
        in_item.temp   = i_temperature;
        in_item.ux_neg = i_velocity_x[W-1];
        in_item.ux_mag = i_velocity_x[W-1] ? (W'(0) - i_velocity_x) : i_velocity_x;
        in_item.uy_neg = i_velocity_y[W-1];
        in_item.uy_mag = i_velocity_y[W-1] ? (W'(0) - i_velocity_y) : i_velocity_y;
        in_item.x_neg  = i_coord_x[W-1];
        in_item.y_neg  = i_coord_y[W-1];
        in_item.last   = i_last_point;
        in_item.tzero  = (i_temperature == '0);
    end

    // ---------------- first divide rank: p/T, x/L, y/L, gamma/(gamma-1) ----------------
    logic         a_vld, a_ovf, hx_ovf;
    logic [W-1:0] a_quo, xa_quo, ya_quo, hx_quo;
    logic [ITEM_W-1:0] a_side;
    logic [W-1:0] x_mag, y_mag;

    assign x_mag = i_coord_x[W-1] ? (W'(0) - i_coord_x) : i_coord_x;
    assign y_mag = i_coord_y[W-1] ? (W'(0) - i_coord_y) : i_coord_y;

    prv_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(ITEM_W)) u_div_pt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(i_valid),
        .i_num(i_pressure), .i_den(i_temperature), .i_side(in_item),
        .o_valid(a_vld), .o_quo(a_quo), .o_ovf(a_ovf), .o_side(a_side)
    );

    prv_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(i_valid),
        .i_num(x_mag), .i_den(r_lref), .i_side(1'b0),
        .o_valid(), .o_quo(xa_quo), .o_ovf(), .o_side()
    );

    prv_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(i_valid),
        .i_num(y_mag), .i_den(r_lref), .i_side(1'b0),
        .o_valid(), .o_quo(ya_quo), .o_ovf(), .o_side()
    );

    prv_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_heat (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(i_valid),
        .i_num(r_gamma), .i_den(r_gm1), .i_side(1'b0),
        .o_valid(), .o_quo(hx_quo), .o_ovf(hx_ovf), .o_side()
    );

    t_item a_item;

    always_comb begin
        a_item       = t_item'(a_side);
        a_item.help  = hx_quo;
        a_item.x_quo = xa_quo;
        a_item.y_quo = ya_quo;
        a_item.sat   = a_item.sat | a_ovf | hx_ovf;
    end

    // ---------------- second and third divide: /R, /Tref ----------------
    logic         b_vld, b_ovf, c_vld, c_ovf;
    logic [W-1:0] b_quo, c_quo;
    logic [ITEM_W-1:0] b_side, c_side;
    t_item b_item, c_item;

    prv_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(ITEM_W)) u_div_gas (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(a_vld),
        .i_num(a_quo), .i_den(r_gas), .i_side(a_item),
        .o_valid(b_vld), .o_quo(b_quo), .o_ovf(b_ovf), .o_side(b_side)
    );

    always_comb begin
        b_item     = t_item'(b_side);
        b_item.sat = b_item.sat | b_ovf;
    end

    prv_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(ITEM_W)) u_div_tref (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(b_vld),
        .i_num(b_quo), .i_den(r_tref), .i_side(b_item),
        .o_valid(c_vld), .o_quo(c_quo), .o_ovf(c_ovf), .o_side(c_side)
    );

    always_comb begin
        c_item     = t_item'(c_side);
        c_item.sat = c_item.sat | c_ovf;
    end

    // ---------------- stage 3: first products ----------------
    logic         r3_vld;
    t_item        r3_item;
    logic [63:0]  r3_prho, r3_pth, r3_kx, r3_ky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (adv) begin
            r3_vld <= c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_item <= c_item;
            r3_prho <= 64'(c_quo) * 64'(r_uref);
            r3_pth  <= 64'(c_item.help) * 64'(r_gas);
            r3_kx   <= 64'(c_item.ux_mag) * 64'(c_item.ux_mag);
            r3_ky   <= 64'(c_item.uy_mag) * 64'(c_item.uy_mag);
        end
    end

    // ---------------- stage 4: second products, kinetic term ----------------
    logic             r4_vld;
    t_item            r4_item, n4_item;
    logic [63:0]      r4_prho2, r4_pth2, n4_prho2, n4_pth2;
    logic [KIN_W-1:0] r4_kin, n4_kin;
    logic [W:0]       n4_rho, n4_th;
    logic [64:0]      n4_ksum;

    always_comb begin
        n4_rho       = f_clamp(r3_prho >> FRAC_BITS);
        n4_th        = f_clamp(r3_pth >> FRAC_BITS);
        n4_prho2     = 64'(n4_rho[W-1:0]) * 64'(r_uref);
        n4_pth2      = 64'(n4_th[W-1:0]) * 64'(r3_item.temp);
        n4_ksum      = {1'b0, r3_kx} + {1'b0, r3_ky};
        n4_kin       = KIN_W'(n4_ksum >> (FRAC_BITS + 1));
        n4_item      = r3_item;
        n4_item.sat  = r3_item.sat | n4_rho[W] | n4_th[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (adv) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_item  <= n4_item;
            r4_prho2 <= n4_prho2;
            r4_pth2  <= n4_pth2;
            r4_kin   <= n4_kin;
        end
    end

    // ---------------- stage 5: density and enthalpy sum ----------------
    logic           r5_vld;
    t_item          r5_item, n5_item;
    logic [W-1:0]   r5_rho;
    logic [KIN_W:0] r5_hsum, n5_hsum;
    logic [W:0]     n5_rho, n5_th;

    always_comb begin
        n5_rho      = f_clamp(r4_prho2 >> FRAC_BITS);
        n5_th       = f_clamp(r4_pth2 >> FRAC_BITS);
        n5_hsum     = (KIN_W+1)'(n5_th[W-1:0]) + (KIN_W+1)'(r4_kin);
        n5_item     = r4_item;
        n5_item.sat = r4_item.sat | n5_rho[W] | n5_th[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (adv) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_item <= n5_item;
            r5_rho  <= n5_rho[W-1:0];
            r5_hsum <= n5_hsum;
        end
    end

    // ---------------- square root ----------------
    t_item             sq_in_item, sq_item;
    logic [W:0]        sq_h;
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    logic [ITEM_W-1:0] sq_side;

    always_comb begin
        sq_h           = f_clamp(64'(r5_hsum));
        sq_in_item      = r5_item;
        sq_in_item.hent = sq_h[W-1:0];
        sq_in_item.sat  = r5_item.sat | sq_h[W];
    end

    prv_sqrt #(.FRAC_BITS(FRAC_BITS), .SIDE_W(ITEM_W)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r5_vld),
        .i_rad(RAD_W'({r5_rho, {FRAC_BITS{1'b0}}})), .i_side(sq_in_item),
        .o_valid(sq_vld), .o_root(sq_root), .o_side(sq_side)
    );

    assign sq_item = t_item'(sq_side);

    // ---------------- stage 6: Roe products ----------------
    logic              r6_vld;
    t_item             r6_item;
    logic [ROOT_W-1:0] r6_root;
    logic [63:0]       r6_ph, r6_px, r6_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (adv) begin
            r6_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_item <= sq_item;
            r6_root <= sq_root;
            r6_ph   <= 64'(sq_root) * 64'(sq_item.hent);
            r6_px   <= 64'(sq_root) * 64'(sq_item.ux_mag);
            r6_py   <= 64'(sq_root) * 64'(sq_item.uy_mag);
        end
    end

    // ---------------- stage 7: sign, saturate, status ----------------
    logic [W:0]    n7_h, n7_ux, n7_uy, n7_x, n7_y;
    logic          n7_sat;
    logic [prv_pkg::STATUS_W-1:0] n7_status;
    logic [W-1:0]  r7_rd, r7_rh, r7_rx, r7_ry, r7_sx, r7_sy;
    logic          r7_last;
    logic [prv_pkg::STATUS_W-1:0] r7_status;

    always_comb begin
        n7_h   = f_sign(1'b0, r6_ph >> FRAC_BITS);
        n7_ux  = f_sign(r6_item.ux_neg, r6_px >> FRAC_BITS);
        n7_uy  = f_sign(r6_item.uy_neg, r6_py >> FRAC_BITS);
        n7_x   = f_sign(r6_item.x_neg, 64'(r6_item.x_quo));
        n7_y   = f_sign(r6_item.y_neg, 64'(r6_item.y_quo));
        n7_sat = r6_item.sat | n7_h[W] | n7_ux[W] | n7_uy[W] | n7_x[W] | n7_y[W];
        priority if (r6_item.tzero) begin
            n7_status = prv_pkg::ST_ZERO_TEMP;
        end else if (n7_sat) begin
            n7_status = prv_pkg::ST_SATURATED;
        end else begin
            n7_status = prv_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (adv) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_rd     <= r6_item.tzero ? '0 : W'(r6_root);
            r7_rh     <= r6_item.tzero ? '0 : n7_h[W-1:0];
            r7_rx     <= r6_item.tzero ? '0 : n7_ux[W-1:0];
            r7_ry     <= r6_item.tzero ? '0 : n7_uy[W-1:0];
            r7_sx     <= n7_x[W-1:0];
            r7_sy     <= n7_y[W-1:0];
            r7_last   <= r6_item.last;
            r7_status <= n7_status;
        end
    end

    assign o_valid                   = r7_vld;
    assign o_root_density            = r7_rd;
    assign o_root_density_enthalpy   = r7_rh;
    assign o_root_density_velocity_x = r7_rx;
    assign o_root_density_velocity_y = r7_ry;
    assign o_scaled_x                = r7_sx;
    assign o_scaled_y                = r7_sy;
    assign o_last_out                = r7_last;
    assign o_status                  = r7_status;

`ifndef SYNTHESIS
    a_zero_temp_clears_roe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == prv_pkg::ST_ZERO_TEMP) |->
            (o_root_density == '0) && (o_root_density_enthalpy == '0) &&
            (o_root_density_velocity_x == '0) && (o_root_density_velocity_y == '0))
        else $error("zero temperature item carries nonzero Roe outputs");

    a_ok_enthalpy_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == prv_pkg::ST_OK) |-> !o_root_density_enthalpy[W-1])
        else $error("unsaturated item has negative enthalpy product");

    a_ok_root_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != prv_pkg::ST_ZERO_TEMP) |->
            ((o_root_density >> ROOT_W) == '0))
        else $error("root density wider than square root unit");
`endif

endmodule

/* hdl/prv_div.sv */
// Pipelined fractional divider: one quotient bit per stage, with overflow check.
module prv_div #(
    parameter int FRAC_BITS = prv_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [prv_pkg::WORD-1:0] i_num,
    input  logic [prv_pkg::WORD-1:0] i_den,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic [prv_pkg::WORD-1:0] o_quo,
    output logic                     o_ovf,
    output logic [SIDE_W-1:0]        o_side
);

    localparam int W = prv_pkg::WORD;

    logic              r_vld  [0:W];
    logic [W-1:0]      r_rem  [0:W];
    logic [W-1:0]      r_low  [0:W];
    logic [W-1:0]      r_quo  [0:W];
    logic [W-1:0]      r_den  [0:W];
    logic              r_ovf  [0:W];
    logic              r_zd   [0:W];
    logic [SIDE_W-1:0] r_side [0:W];

    logic n_ovf;

    // quotient reaches 2^W exactly when num * 2^F >= den * 2^W
    always_comb begin
        n_ovf = (i_num != '0) &&
                ((2*W)'(i_num) >= ((2*W)'(i_den) << (W - FRAC_BITS)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= W'(i_num >> (W - FRAC_BITS));
            r_low[0]  <= i_num << FRAC_BITS;
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_ovf[0]  <= n_ovf;
            r_zd[0]   <= (i_den == '0);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_step
        logic [W:0]   n_cur;
        logic         n_ge;
        logic [W-1:0] n_rem;

        always_comb begin
            n_cur = {r_rem[k-1], r_low[k-1][W-1]};
            n_ge  = n_cur >= {1'b0, r_den[k-1]};
            n_rem = n_ge ? W'(n_cur - {1'b0, r_den[k-1]}) : n_cur[W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= r_low[k-1] << 1;
                r_quo[k]  <= {r_quo[k-1][W-2:0], n_ge};
                r_den[k]  <= r_den[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_zd[k]   <= r_zd[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[W];
    assign o_ovf   = r_ovf[W];
    assign o_side  = r_side[W];
    // saturate on overflow, zero for zero over zero
    assign o_quo   = r_ovf[W] ? '1 : (r_zd[W] ? '0 : r_quo[W]);

endmodule

/* hdl/prv_sqrt.sv */
// Pipelined integer square root: one root bit per stage.
module prv_sqrt #(
    parameter int FRAC_BITS = prv_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W = 1
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_en,
    input  logic                                            i_valid,
    input  logic [prv_pkg::WORD+FRAC_BITS-1:0]              i_rad,
    input  logic [SIDE_W-1:0]                               i_side,
    output logic                                            o_valid,
    output logic [(prv_pkg::WORD+FRAC_BITS+1)/2-1:0]        o_root,
    output logic [SIDE_W-1:0]                               o_side
);

    localparam int RAD_W = prv_pkg::WORD + FRAC_BITS;
    localparam int STEPS = (RAD_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int RW = STEPS;

    logic              r_vld  [0:STEPS-1];
    logic [RW+1:0]     r_rem  [0:STEPS-1];
    logic [RW-1:0]     r_root [0:STEPS-1];
    logic [PAD_W-1:0]  r_rad  [0:STEPS-1];
    logic [SIDE_W-1:0] r_side [0:STEPS-1];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [RW+1:0]    n_cur;
        logic [RW+1:0]    n_trial;
        logic [RW+1:0]    n_rem_in;
        logic [RW-1:0]    n_root_in;
        logic [PAD_W-1:0] n_rad_in;
        logic             n_vld_in;
        logic [SIDE_W-1:0] n_side_in;
        logic             n_ge;

        always_comb begin
            if (k == 0) begin
                n_rem_in  = '0;
                n_root_in = '0;
                n_rad_in  = PAD_W'(i_rad);
                n_vld_in  = i_valid;
                n_side_in = i_side;
            end else begin
                n_rem_in  = r_rem[(k == 0) ? 0 : k-1];
                n_root_in = r_root[(k == 0) ? 0 : k-1];
                n_rad_in  = r_rad[(k == 0) ? 0 : k-1];
                n_vld_in  = r_vld[(k == 0) ? 0 : k-1];
                n_side_in = r_side[(k == 0) ? 0 : k-1];
            end
            n_cur   = {n_rem_in[RW-1:0], n_rad_in[PAD_W-1 -: 2]};
            n_trial = {n_root_in, 2'b01};
            n_ge    = n_cur >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= n_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? (n_cur - n_trial) : n_cur;
                r_root[k] <= {n_root_in[RW-2:0], n_ge};
                r_rad[k]  <= n_rad_in << 2;
                r_side[k] <= n_side_in;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_root  = r_root[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule
